FILE: hdl/hvsf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvsf_pkg
// Types, constants and the arctangent table shared by the heading filter.
// ----------------------------------------------------------------------------
package hvsf_pkg;

   localparam int CordicIterations = 16;
   localparam int AngleWidth       = 27;
   localparam int VecWidth         = 20;
   localparam int UnitWidth        = 18;

   typedef logic signed [AngleWidth-1:0] angle_type;
   typedef logic signed [VecWidth-1:0]   vec_type;
   typedef logic signed [UnitWidth-1:0]  unit_type;

   localparam angle_type Deg90  = 27'sd5898240;
   localparam angle_type Deg180 = 27'sd11796480;
   localparam angle_type Deg360 = 27'sd23592960;

   localparam vec_type    CordicStart     = 20'sd39797;
   localparam unit_type   UnitOne         = 18'sd65536;
   localparam logic [7:0] IntervalReset   = 8'd30;
   localparam logic [15:0] GainReset      = 16'd6554;
   localparam logic [15:0] TrackWrap      = 16'd36000;
   localparam logic [15:0] TrackZeroVec   = 16'd9000;

   localparam logic RegUpdateInterval = 1'b0;
   localparam logic RegSmoothingGain  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DIV, ST_ROT_START, ST_ROT, ST_SMOOTH, ST_VEC_START,
      ST_VEC, ST_SCALE, ST_FINISH, ST_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic vectoring;
   } cordic_cmd_type;

   function automatic angle_type atan_q16(input logic [4:0] idx);
      angle_type v;
      case (idx)
         5'd0:  v = 27'sd2949120;
         5'd1:  v = 27'sd1740967;
         5'd2:  v = 27'sd919879;
         5'd3:  v = 27'sd466945;
         5'd4:  v = 27'sd234379;
         5'd5:  v = 27'sd117305;
         5'd6:  v = 27'sd58666;
         5'd7:  v = 27'sd29335;
         5'd8:  v = 27'sd14668;
         5'd9:  v = 27'sd7334;
         5'd10: v = 27'sd3667;
         5'd11: v = 27'sd1833;
         5'd12: v = 27'sd917;
         5'd13: v = 27'sd458;
         5'd14: v = 27'sd229;
         5'd15: v = 27'sd115;
         5'd16: v = 27'sd57;
         5'd17: v = 27'sd29;
         5'd18: v = 27'sd14;
         5'd19: v = 27'sd7;
         5'd20: v = 27'sd4;
         5'd21: v = 27'sd2;
         5'd22: v = 27'sd1;
         default: v = 27'sd0;
      endcase
      return v;
   endfunction

   function automatic unit_type clamp_unit(input vec_type v);
      unit_type r;
      if (v > 20'sd65536) begin
         r = UnitOne;
      end else if (v < -20'sd65536) begin
         r = -UnitOne;
      end else begin
         r = v[UnitWidth-1:0];
      end
      return r;
   endfunction

endpackage

FILE: hdl/hvsf_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvsf_cordic
// Iterative CORDIC, one micro-rotation per cycle, rotation or vectoring mode.
// ----------------------------------------------------------------------------
module hvsf_cordic #(
   parameter int ITERATIONS = hvsf_pkg::CordicIterations
) (
   input  logic                      clock,
   input  logic                      reset,
   input  hvsf_pkg::cordic_cmd_type  cmd,
   input  hvsf_pkg::vec_type         x_start,
   input  hvsf_pkg::vec_type         y_start,
   input  hvsf_pkg::angle_type       z_start,
   output hvsf_pkg::vec_type         x_out,
   output hvsf_pkg::vec_type         y_out,
   output hvsf_pkg::angle_type       z_out,
   output logic                      done
);

   localparam int CntWidth = $clog2(ITERATIONS + 1);
   localparam logic [CntWidth-1:0] LastStep = CntWidth'(ITERATIONS - 1);

   hvsf_pkg::vec_type   x_ff, x_in, y_ff, y_in;
   hvsf_pkg::angle_type z_ff, z_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in, vec_ff, vec_in, done_ff, done_in;
   logic                pos;
   hvsf_pkg::vec_type   xs, ys;
   hvsf_pkg::angle_type at;

   always_comb begin
      xs  = x_ff >>> cnt_ff;
      ys  = y_ff >>> cnt_ff;
      at  = hvsf_pkg::atan_q16(5'(cnt_ff));
      pos = vec_ff ? y_ff[hvsf_pkg::VecWidth-1] : !z_ff[hvsf_pkg::AngleWidth-1];
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      vec_in  = vec_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         x_in    = x_start;
         y_in    = y_start;
         z_in    = z_start;
         cnt_in  = '0;
         busy_in = 1'b1;
         vec_in  = cmd.vectoring;
      end else if (busy_ff) begin
         if (pos) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + at;
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LastStep) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      cnt_ff <= cnt_in;
      vec_ff <= vec_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;
   assign done  = done_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("cordic done without a pass");
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !cmd.start) else $error("cordic restarted while busy");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff <= LastStep) else $error("cordic count overran");

endmodule

FILE: hdl/heading_vector_smoothing_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heading_vector_smoothing_filter
// Smooths the track of good fixes as a unit vector and flags home updates.
// ----------------------------------------------------------------------------
//  channel  ports                      direction
//  req      req_valid/req_stall/req_*  in, one fix per beat
//  rsp      rsp_valid/rsp_stall/rsp_*  out, one result per beat
//  csr      csr_write/csr_index/csr_data  in, register writes
//
// A good fix runs the bit-serial divide by 100, a 16-step CORDIC rotation,
// the bit-serial smoothing multiplies and a 16-step CORDIC vectoring pass.
// A fix that is not good skips them. One fix is in work at a time.
// Synchronous reset clears the filter and loads the countdown with 30.
// The result register holds under rsp_stall while the next fix is taken.
// ----------------------------------------------------------------------------
module heading_vector_smoothing_filter #(
   parameter int CORDIC_ITERATIONS = hvsf_pkg::CordicIterations
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_fix_fresh,
   input  logic [1:0]         req_fix_mode,
   input  logic               req_lat_valid,
   input  logic               req_lon_valid,
   input  logic               req_track_valid,
   input  logic signed [34:0] req_lat_e8,
   input  logic signed [35:0] req_lon_e8,
   input  logic [15:0]        req_track_cdeg,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_fix_used,
   output logic [15:0]        rsp_filtered_track_cdeg,
   output logic               rsp_home_due,
   output logic signed [34:0] rsp_home_lat_e8,
   output logic signed [35:0] rsp_home_lon_e8,
   input  logic               csr_write,
   input  logic               csr_index,
   input  logic [15:0]        csr_data
);

   hvsf_pkg::state_type state_ff, state_in;

   logic [7:0]  interval_ff;
   logic [15:0] gain_ff;
   hvsf_pkg::unit_type east_ff, east_in, north_ff, north_in;
   logic [15:0] track_ff, track_in;
   logic signed [8:0] count_ff, count_in;

   logic               good_ff, good_in;
   logic signed [34:0] lat_ff, lat_in;
   logic signed [35:0] lon_ff, lon_in;
   logic               home_ff, home_in;

   logic [31:0] dvd_ff, dvd_in;
   logic [6:0]  rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [5:0]  step_ff, step_in;
   logic        neg_ff, neg_in;

   logic [16:0] ma_ff, ma_in, mg_ff, mg_in;
   logic signed [37:0] oe_ff, oe_in, on_ff, on_in, se_ff, se_in, sn_ff, sn_in;
   logic signed [37:0] acce_ff, acce_in, accn_ff, accn_in;
   hvsf_pkg::angle_type z_ff, z_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_used_ff, out_used_in, out_home_ff, out_home_in;
   logic [15:0]        out_track_ff, out_track_in;
   logic signed [34:0] out_lat_ff, out_lat_in;
   logic signed [35:0] out_lon_ff, out_lon_in;

   hvsf_pkg::cordic_cmd_type cmd;
   hvsf_pkg::vec_type   cx_start, cy_start, cx, cy;
   hvsf_pkg::angle_type cz_start, cz;
   logic                cdone;

   logic [7:0]          rtry;
   hvsf_pkg::angle_type ang;
   hvsf_pkg::vec_type   vn, ve;
   logic signed [34:0]  zw, prod;
   logic signed [18:0]  r;
   logic signed [8:0]   dec;
   logic                accept, out_free;

   hvsf_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .x_start (cx_start),
      .y_start (cy_start),
      .z_start (cz_start),
      .x_out   (cx),
      .y_out   (cy),
      .z_out   (cz),
      .done    (cdone)
   );

   assign req_stall = (state_ff != hvsf_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      east_in      = east_ff;
      north_in     = north_ff;
      track_in     = track_ff;
      count_in     = count_ff;
      good_in      = good_ff;
      lat_in       = lat_ff;
      lon_in       = lon_ff;
      home_in      = home_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      neg_in       = neg_ff;
      ma_in        = ma_ff;
      mg_in        = mg_ff;
      oe_in        = oe_ff;
      on_in        = on_ff;
      se_in        = se_ff;
      sn_in        = sn_ff;
      acce_in      = acce_ff;
      accn_in      = accn_ff;
      z_in         = z_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      out_used_in  = out_used_ff;
      out_home_in  = out_home_ff;
      out_track_in = out_track_ff;
      out_lat_in   = out_lat_ff;
      out_lon_in   = out_lon_ff;
      cmd          = '0;
      cx_start     = hvsf_pkg::CordicStart;
      cy_start     = '0;
      cz_start     = '0;
      rtry         = {rem_ff, dvd_ff[31]};
      ang          = hvsf_pkg::angle_type'(quo_ff[25:0]);
      vn           = hvsf_pkg::vec_type'(north_ff);
      ve           = hvsf_pkg::vec_type'(east_ff);
      zw           = 35'(z_ff);
      prod         = (zw <<< 6) + (zw <<< 5) + (zw <<< 2) + 35'sd32768;
      r            = prod[34:16];
      dec          = count_ff - 9'sd1;

      case (state_ff)
         hvsf_pkg::ST_IDLE: begin
            if (accept) begin
               good_in = req_fix_fresh && (req_fix_mode > 2'd1) && req_lat_valid
                         && req_lon_valid && req_track_valid;
               lat_in  = req_lat_e8;
               lon_in  = req_lon_e8;
               home_in = 1'b0;
               track_in = track_ff;
               dvd_in  = {(req_track_cdeg >= hvsf_pkg::TrackWrap) ?
                          req_track_cdeg - hvsf_pkg::TrackWrap : req_track_cdeg,
                          16'd50};
               rem_in  = '0;
               quo_in  = '0;
               step_in = '0;
               state_in = good_in ? hvsf_pkg::ST_DIV : hvsf_pkg::ST_DONE;
            end
         end
         hvsf_pkg::ST_DIV: begin
            if (rtry >= 8'd100) begin
               rem_in = 7'(rtry - 8'd100);
               quo_in = {quo_ff[30:0], 1'b1};
            end else begin
               rem_in = rtry[6:0];
               quo_in = {quo_ff[30:0], 1'b0};
            end
            dvd_in  = {dvd_ff[30:0], 1'b0};
            step_in = step_ff + 6'd1;
            if (step_ff == 6'd31) begin
               state_in = hvsf_pkg::ST_ROT_START;
            end
         end
         hvsf_pkg::ST_ROT_START: begin
            if (ang > hvsf_pkg::Deg180) begin
               ang = ang - hvsf_pkg::Deg360;
            end
            neg_in = 1'b0;
            if (ang > hvsf_pkg::Deg90) begin
               ang    = ang - hvsf_pkg::Deg180;
               neg_in = 1'b1;
            end else if (ang < -hvsf_pkg::Deg90) begin
               ang    = ang + hvsf_pkg::Deg180;
               neg_in = 1'b1;
            end
            cmd.start = 1'b1;
            cz_start  = ang;
            state_in  = hvsf_pkg::ST_ROT;
         end
         hvsf_pkg::ST_ROT: begin
            if (cdone) begin
               ma_in   = 17'd65536 - {1'b0, gain_ff};
               mg_in   = {1'b0, gain_ff};
               oe_in   = 38'(east_ff);
               on_in   = 38'(north_ff);
               se_in   = 38'(hvsf_pkg::clamp_unit(neg_ff ? -cy : cy));
               sn_in   = 38'(hvsf_pkg::clamp_unit(neg_ff ? -cx : cx));
               acce_in = 38'sd32768;
               accn_in = 38'sd32768;
               step_in = '0;
               state_in = hvsf_pkg::ST_SMOOTH;
            end
         end
         hvsf_pkg::ST_SMOOTH: begin
            acce_in = acce_ff + (ma_ff[0] ? oe_ff : 38'sd0) + (mg_ff[0] ? se_ff : 38'sd0);
            accn_in = accn_ff + (ma_ff[0] ? on_ff : 38'sd0) + (mg_ff[0] ? sn_ff : 38'sd0);
            ma_in   = ma_ff >> 1;
            mg_in   = mg_ff >> 1;
            oe_in   = oe_ff <<< 1;
            on_in   = on_ff <<< 1;
            se_in   = se_ff <<< 1;
            sn_in   = sn_ff <<< 1;
            step_in = step_ff + 6'd1;
            if (step_ff == 6'd16) begin
               east_in  = acce_in[33:16];
               north_in = accn_in[33:16];
               state_in = hvsf_pkg::ST_VEC_START;
            end
         end
         hvsf_pkg::ST_VEC_START: begin
            if (vn == '0 && ve == '0) begin
               track_in = hvsf_pkg::TrackZeroVec;
               state_in = hvsf_pkg::ST_FINISH;
            end else begin
               cmd.start     = 1'b1;
               cmd.vectoring = 1'b1;
               if (vn < 0) begin
                  cx_start = -vn;
                  cy_start = -ve;
                  cz_start = hvsf_pkg::Deg180;
               end else begin
                  cx_start = vn;
                  cy_start = ve;
                  cz_start = '0;
               end
               state_in = hvsf_pkg::ST_VEC;
            end
         end
         hvsf_pkg::ST_VEC: begin
            if (cdone) begin
               z_in = (cz < 0) ? cz + hvsf_pkg::Deg360 : cz;
               state_in = hvsf_pkg::ST_SCALE;
            end
         end
         hvsf_pkg::ST_SCALE: begin
            if (r >= 19'sd36000) begin
               r = r - 19'sd36000;
            end else if (r < 0) begin
               r = r + 19'sd36000;
            end
            track_in = r[15:0];
            state_in = hvsf_pkg::ST_FINISH;
         end
         hvsf_pkg::ST_FINISH: begin
            if (dec < 0) begin
               home_in  = 1'b1;
               count_in = 9'(interval_ff);
            end else begin
               count_in = dec;
            end
            state_in = hvsf_pkg::ST_DONE;
         end
         hvsf_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_used_in  = good_ff;
               out_home_in  = home_ff;
               out_track_in = track_ff;
               out_lat_in   = home_ff ? lat_ff : '0;
               out_lon_in   = home_ff ? lon_ff : '0;
               state_in     = hvsf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hvsf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      lat_ff       <= lat_in;
      lon_ff       <= lon_in;
      dvd_ff       <= dvd_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      step_ff      <= step_in;
      neg_ff       <= neg_in;
      ma_ff        <= ma_in;
      mg_ff        <= mg_in;
      oe_ff        <= oe_in;
      on_ff        <= on_in;
      se_ff        <= se_in;
      sn_ff        <= sn_in;
      acce_ff      <= acce_in;
      accn_ff      <= accn_in;
      z_ff         <= z_in;
      good_ff      <= good_in;
      home_ff      <= home_in;
      out_used_ff  <= out_used_in;
      out_home_ff  <= out_home_in;
      out_track_ff <= out_track_in;
      out_lat_ff   <= out_lat_in;
      out_lon_ff   <= out_lon_in;
      if (reset) begin
         state_ff     <= hvsf_pkg::ST_IDLE;
         interval_ff  <= hvsf_pkg::IntervalReset;
         gain_ff      <= hvsf_pkg::GainReset;
         east_ff      <= '0;
         north_ff     <= '0;
         track_ff     <= '0;
         count_ff     <= 9'(hvsf_pkg::IntervalReset);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         east_ff      <= east_in;
         north_ff     <= north_in;
         track_ff     <= track_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write && csr_index == hvsf_pkg::RegUpdateInterval) begin
            interval_ff <= csr_data[7:0];
         end
         if (csr_write && csr_index == hvsf_pkg::RegSmoothingGain) begin
            gain_ff <= csr_data;
         end
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_fix_used            = out_used_ff;
   assign rsp_filtered_track_cdeg = out_track_ff;
   assign rsp_home_due            = out_home_ff;
   assign rsp_home_lat_e8         = out_lat_ff;
   assign rsp_home_lon_e8         = out_lon_ff;

   a_home_needs_use: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!out_home_ff || out_used_ff)) else $error("home without used fix");
   a_track_range: assert property (@(posedge clock) disable iff (reset)
      track_ff < hvsf_pkg::TrackWrap) else $error("track out of range");
   a_countdown_range: assert property (@(posedge clock) disable iff (reset)
      count_ff >= 0) else $error("countdown negative");
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != hvsf_pkg::ST_IDLE) else $error("fix taken without work");

endmodule

FILE: sim/heading_vector_smoothing_filter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heading_vector_smoothing_filter_tb
// Self-checking bench for the heading smoothing filter. Directed fixes cover
// the field extremes, every fix mode and each reason a fix is rejected. They
// also cover track wrap, a frozen filter at zero gain and a countdown of zero.
// Random fixes follow under several register settings, with random gaps and
// stalls. A predictor rebuilt in fixed point holds its own filter and
// countdown state. It checks every result beat field by field, in order.
// ----------------------------------------------------------------------------
module heading_vector_smoothing_filter_tb;

   typedef struct packed {
      logic               fresh;
      logic [1:0]         mode;
      logic               lat_ok;
      logic               lon_ok;
      logic               track_ok;
      logic signed [34:0] lat;
      logic signed [35:0] lon;
      logic [15:0]        track;
   } fix_beat_type;

   typedef struct packed {
      logic               used;
      logic [15:0]        track;
      logic               home;
      logic signed [34:0] lat;
      logic signed [35:0] lon;
   } track_result_type;

   class heading_scoreboard;
      track_result_type pending_tracks[$];
      int            errors;
      longint        interval;
      longint        gain;
      longint        east_q16;
      longint        north_q16;
      int            held_track;
      longint        countdown;
      longint        arctan_q16[16];

      function void clear_state();
         interval   = 30;
         gain       = 6554;
         east_q16   = 0;
         north_q16  = 0;
         held_track = 0;
         countdown  = 30;
         errors     = 0;
         arctan_q16 = '{2949120, 1740967, 919879, 466945, 234379, 117305, 58666,
                        29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};
      endfunction

      function longint to_unit(longint v);
         if (v > 65536) return 65536;
         if (v < -65536) return -65536;
         return v;
      endfunction

      function void track_to_vector(int t, output longint e, output longint n);
         longint a, x, y, nx;
         bit     flip;
         a    = (longint'(t) * 65536 + 50) / 100;
         x    = 39797;
         y    = 0;
         flip = 0;
         if (a > 180 * 65536) a -= 360 * 65536;
         if (a > 90 * 65536) begin
            a -= 180 * 65536;
            flip = 1;
         end else if (a < -90 * 65536) begin
            a += 180 * 65536;
            flip = 1;
         end
         for (int i = 0; i < 16; i++) begin
            if (a >= 0) begin
               nx = x - (y >>> i);
               y  = y + (x >>> i);
               a -= arctan_q16[i];
            end else begin
               nx = x + (y >>> i);
               y  = y - (x >>> i);
               a += arctan_q16[i];
            end
            x = nx;
         end
         if (flip) begin
            x = -x;
            y = -y;
         end
         e = to_unit(y);
         n = to_unit(x);
      endfunction

      function int vector_to_track(longint e, longint n);
         longint x, y, z, nx, r;
         x = n;
         y = e;
         z = 0;
         if (x == 0 && y == 0) return 9000;
         if (x < 0) begin
            x = -x;
            y = -y;
            z = 180 * 65536;
         end
         for (int i = 0; i < 16; i++) begin
            if (y >= 0) begin
               nx = x + (y >>> i);
               y  = y - (x >>> i);
               z += arctan_q16[i];
            end else begin
               nx = x - (y >>> i);
               y  = y + (x >>> i);
               z -= arctan_q16[i];
            end
            x = nx;
         end
         if (z < 0) z += 360 * 65536;
         r = (z * 100 + 32768) >>> 16;
         if (r >= 36000) r -= 36000;
         if (r < 0) r += 36000;
         return int'(r);
      endfunction

      function longint blend(longint old, longint sample);
         return ((65536 - gain) * old + gain * sample + 32768) >>> 16;
      endfunction

      function void note_fix(fix_beat_type f);
         track_result_type r;
         longint        e, n;
         bit            good;
         good = f.fresh && f.mode > 1 && f.lat_ok && f.lon_ok && f.track_ok;
         r    = '0;
         if (good) begin
            track_to_vector(int'(f.track) % 36000, e, n);
            east_q16   = blend(east_q16, e);
            north_q16  = blend(north_q16, n);
            held_track = vector_to_track(east_q16, north_q16);
            countdown--;
            if (countdown < 0) begin
               r.home    = 1'b1;
               r.lat     = f.lat;
               r.lon     = f.lon;
               countdown = interval;
            end
         end
         r.used  = good;
         r.track = 16'(held_track);
         pending_tracks.push_back(r);
      endfunction

      function void check_track_result(track_result_type act);
         track_result_type exp;
         if (pending_tracks.size() == 0) begin
            $display("%0t: unexpected result beat", $time);
            errors++;
            return;
         end
         exp = pending_tracks.pop_front();
         if (act.used !== exp.used) begin
            $display("%0t: fix_used exp %0d act %0d", $time, exp.used, act.used);
            errors++;
         end
         if (act.track !== exp.track) begin
            $display("%0t: filtered_track exp %0d act %0d", $time, exp.track, act.track);
            errors++;
         end
         if (act.home !== exp.home) begin
            $display("%0t: home_due exp %0d act %0d", $time, exp.home, act.home);
            errors++;
         end
         if (act.lat !== exp.lat) begin
            $display("%0t: home_lat exp %0d act %0d", $time, exp.lat, act.lat);
            errors++;
         end
         if (act.lon !== exp.lon) begin
            $display("%0t: home_lon exp %0d act %0d", $time, exp.lon, act.lon);
            errors++;
         end
      endfunction
   endclass

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_stall;
   logic               req_fix_fresh = 0;
   logic [1:0]         req_fix_mode = '0;
   logic               req_lat_valid = 0;
   logic               req_lon_valid = 0;
   logic               req_track_valid = 0;
   logic signed [34:0] req_lat_e8 = '0;
   logic signed [35:0] req_lon_e8 = '0;
   logic [15:0]        req_track_cdeg = '0;
   logic               rsp_valid;
   logic               rsp_stall = 0;
   logic               rsp_fix_used;
   logic [15:0]        rsp_filtered_track_cdeg;
   logic               rsp_home_due;
   logic signed [34:0] rsp_home_lat_e8;
   logic signed [35:0] rsp_home_lon_e8;
   logic               csr_write = 0;
   logic               csr_index = 0;
   logic [15:0]        csr_data = '0;

   heading_scoreboard sb;
   bit                no_gaps = 0;
   longint            cycle_count = 0;

   heading_vector_smoothing_filter DUT (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 2000000) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_track_result({rsp_fix_used, rsp_filtered_track_cdeg, rsp_home_due,
                                rsp_home_lat_e8, rsp_home_lon_e8});
      end
   end

   initial begin : result_stall
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            hold = no_gaps ? 0 : $urandom_range(13);
         end else if (hold > 0) begin
            hold--;
         end
         rsp_stall <= (hold > 0);
      end
   end

   function automatic fix_beat_type make_fix(int fr, int md, int la, int lo,
                                             int tr, longint lat, longint lon, int trk);
      fix_beat_type f;
      f.fresh    = 1'(fr);
      f.mode     = 2'(md);
      f.lat_ok   = 1'(la);
      f.lon_ok   = 1'(lo);
      f.track_ok = 1'(tr);
      f.lat      = 35'(lat);
      f.lon      = 36'(lon);
      f.track    = 16'(trk);
      return f;
   endfunction

   function automatic fix_beat_type random_fix();
      longint    lat, lon;
      fix_beat_type f;
      lat = $signed({$urandom, $urandom}) % 64'sd9000000001;
      lon = $signed({$urandom, $urandom}) % 64'sd18000000001;
      if ($urandom_range(99) < 75) begin
         f = make_fix(1, 2 + $urandom_range(1), 1, 1, 1, lat, lon, 0);
      end else begin
         f = make_fix($urandom_range(1), $urandom_range(3), $urandom_range(1),
                      $urandom_range(1), $urandom_range(1), lat, lon, 0);
      end
      f.track = ($urandom_range(9) == 0) ? 16'($urandom_range(65535))
                                         : 16'($urandom_range(35999));
      return f;
   endfunction

   task automatic send_fix(fix_beat_type f);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(13);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1;
      req_fix_fresh   <= f.fresh;
      req_fix_mode    <= f.mode;
      req_lat_valid   <= f.lat_ok;
      req_lon_valid   <= f.lon_ok;
      req_track_valid <= f.track_ok;
      req_lat_e8      <= f.lat;
      req_lon_e8      <= f.lon;
      req_track_cdeg  <= f.track;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_fix(f);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending_tracks.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [15:0] value);
      drain();
      csr_write <= 1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      csr_write <= 0;
      if (idx == hvsf_pkg::RegUpdateInterval) sb.interval = longint'(value[7:0]);
      else sb.gain = longint'(value);
   endtask

   initial begin
      int interval_set[5] = '{1, 255, 0, 7, 30};
      int gain_set[5]     = '{65535, 1, 0, 32768, 6554};
      sb = new();
      sb.clear_state();
      repeat (4) @(posedge clock);
      reset <= 0;

      // directed fixes under reset settings
      send_fix(make_fix(1, 3, 1, 1, 1, 9000000000, 18000000000, 0));
      send_fix(make_fix(1, 2, 1, 1, 1, -9000000000, -18000000000, 35999));
      send_fix(make_fix(1, 3, 1, 1, 1, 0, 0, 36000));
      send_fix(make_fix(1, 3, 1, 1, 1, -1, -1, 65535));
      send_fix(make_fix(1, 2, 1, 1, 1, 1, 1, 9000));
      send_fix(make_fix(1, 3, 1, 1, 1, 123, 456, 18000));
      send_fix(make_fix(1, 3, 1, 1, 1, 7, 8, 27000));
      send_fix(make_fix(0, 3, 1, 1, 1, 5, 5, 100));
      send_fix(make_fix(1, 0, 1, 1, 1, 5, 5, 100));
      send_fix(make_fix(1, 1, 1, 1, 1, 5, 5, 100));
      send_fix(make_fix(1, 3, 0, 1, 1, 5, 5, 100));
      send_fix(make_fix(1, 3, 1, 0, 1, 5, 5, 100));
      send_fix(make_fix(1, 3, 1, 1, 0, 5, 5, 100));
      send_fix(make_fix(0, 0, 0, 0, 0, -9000000000, 18000000000, 65535));
      for (int k = 0; k < 20; k++) send_fix(make_fix(1, 3, 1, 1, 1, k, -k, 4500));

      // frozen filter and countdown of zero
      write_reg(hvsf_pkg::RegSmoothingGain, 16'd0);
      write_reg(hvsf_pkg::RegUpdateInterval, 16'd0);
      send_fix(make_fix(1, 3, 1, 1, 1, 11, 22, 1000));
      send_fix(make_fix(1, 3, 1, 1, 1, 33, 44, 20000));

      for (int p = 0; p < 5; p++) begin
         write_reg(hvsf_pkg::RegUpdateInterval, 16'(interval_set[p]));
         write_reg(hvsf_pkg::RegSmoothingGain, 16'(gain_set[p]));
         no_gaps = (p == 3);
         for (int k = 0; k < 205; k++) begin
            if (k == 100) drain();
            send_fix(random_fix());
         end
      end

      drain();
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

FILE: sim.f
hdl/hvsf_pkg.sv
hdl/hvsf_cordic.sv
hdl/heading_vector_smoothing_filter.sv
sim/heading_vector_smoothing_filter_tb.sv
